[hw/rtl/ppft_pkg.sv]
// shared constants, command codes and control structs for the page frame table
// no dependencies
package ppft_pkg;

  localparam int NUM_FRAMES_DEF = 16;
  localparam int PID_BITS_DEF   = 8;
  localparam int PAGE_BITS_DEF  = 16;

  localparam int CMD_W   = 2;
  localparam int PID_W   = 8;
  localparam int PAGE_W  = 16;
  localparam int FRAME_W = 4;
  localparam int FAULT_W = 16;

  localparam logic [CMD_W-1:0] CMD_ACCESS  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  typedef struct packed {
    logic rd;
    logic wr;
    logic free;
    logic clr;
  } tag_ctl_t;

  typedef struct packed {
    logic used;
    logic owner_hit;
    logic tag_hit;
  } tag_sts_t;

  typedef struct packed {
    logic restart;
    logic rd;
    logic pop;
    logic push;
  } ring_ctl_t;

endpackage

[hw/rtl/ppft_if.sv]
// valid/ready channel interfaces for command words and result words
// depends on ppft_pkg
interface ppft_in_if import ppft_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [PID_W-1:0]  pid;
  logic [PAGE_W-1:0] page;

  modport source (output valid, output cmd, output pid, output page, input ready);
  modport sink   (input valid, input cmd, input pid, input page, output ready);
endinterface

interface ppft_out_if import ppft_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic [FRAME_W-1:0] frame;
  logic [FAULT_W-1:0] fault_count;

  modport source (output valid, output hit, output frame, output fault_count, input ready);
  modport sink   (input valid, input hit, input frame, input fault_count, output ready);
endinterface

[hw/rtl/ppft_tag_store.sv]
// frame tag memory with used bits and the shared tag comparator
// depends on ppft_pkg
module ppft_tag_store import ppft_pkg::*; #(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int PID_BITS   = PID_BITS_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF,
  localparam int IDX_W     = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tag_ctl_t             ctl,
  input  logic [IDX_W-1:0]     addr,
  input  logic [PID_BITS-1:0]  pid,
  input  logic [PAGE_BITS-1:0] page,
  output tag_sts_t             sts
);

  logic [PID_BITS+PAGE_BITS-1:0] tag_mem [NUM_FRAMES];
  logic [NUM_FRAMES-1:0]         used_r;
  logic [PID_BITS-1:0]           rd_pid_r;
  logic [PAGE_BITS-1:0]          rd_page_r;
  logic                          rd_used_r;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      tag_mem[addr] <= {pid, page};
    end
    if (ctl.rd) begin
      {rd_pid_r, rd_page_r} <= tag_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      rd_used_r <= 1'b0;
    end else begin
      if (ctl.rd) begin
        rd_used_r <= used_r[addr];
      end
      if (ctl.clr) begin
        used_r <= '0;
      end else if (ctl.wr) begin
        used_r[addr] <= 1'b1;
      end else if (ctl.free) begin
        used_r[addr] <= 1'b0;
      end
    end
  end

  // free frames never match, whatever their stale tags hold
  always_comb begin
    sts.used      = rd_used_r;
    sts.owner_hit = rd_used_r && (rd_pid_r == pid);
    sts.tag_hit   = sts.owner_hit && (rd_page_r == page);
  end

endmodule

[hw/rtl/ppft_ring.sv]
// fifo ring of occupied frame indices with head pointer and fill count
// depends on ppft_pkg
module ppft_ring import ppft_pkg::*; #(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF,
  localparam int IDX_W     = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ring_ctl_t        ctl,
  input  logic [IDX_W-1:0] push_idx,
  output logic [IDX_W-1:0] head_idx
);

  localparam int CNT_W = $clog2(NUM_FRAMES + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [SUM_W-1:0] N_SUM  = SUM_W'(NUM_FRAMES);
  localparam logic [CNT_W-1:0] N_CNT  = CNT_W'(NUM_FRAMES);
  localparam logic [IDX_W-1:0] LAST   = IDX_W'(NUM_FRAMES - 1);

  logic [IDX_W-1:0] ring_mem [NUM_FRAMES];
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] rd_data_r;
  logic [CNT_W-1:0] cnt_pop;
  logic [SUM_W-1:0] sum, pos;
  logic             do_pop, do_push;

  always_comb begin
    do_pop   = ctl.pop && (count_r != '0);
    head_nxt = head_r;
    if (do_pop) begin
      head_nxt = (head_r == LAST) ? '0 : head_r + 1'b1;
    end
    cnt_pop  = count_r - CNT_W'(do_pop);
    do_push  = ctl.push && (cnt_pop < N_CNT);
    // tail slot, wrapped with one compare and subtract
    sum      = SUM_W'(head_nxt) + SUM_W'(cnt_pop);
    pos      = (sum >= N_SUM) ? sum - N_SUM : sum;
    count_nxt = cnt_pop + CNT_W'(do_push);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (ctl.restart) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push && !ctl.restart) begin
      ring_mem[pos[IDX_W-1:0]] <= push_idx;
    end
    if (ctl.rd) begin
      rd_data_r <= ring_mem[head_r];
    end
  end

  assign head_idx = rd_data_r;

endmodule

[hw/rtl/fifo_page_frame_table_top.sv]
// access: one tag read and one compare per frame on the shared comparator (S_RD then
// S_CMP), stopping at a hit, with an S_FILL step on a miss; release walks every frame;
// clear and unused codes go straight to S_DONE. one word in flight, next word taken the
// cycle after the result is registered, and a result word that waits on ready holds
// the block in S_DONE. synchronous active-low reset empties the table, ring and
// counter.
module fifo_page_frame_table_top import ppft_pkg::*; #(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int PID_BITS   = PID_BITS_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  ppft_in_if.sink   in_ch,
  ppft_out_if.source out_ch
);

  localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_FRAMES - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_CMP  = 5'b00100,
    S_FILL = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [PID_BITS-1:0]  pid_r, pid_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [IDX_W-1:0]     free_idx_r, free_idx_nxt;
  logic                 free_fnd_r, free_fnd_nxt;
  logic                 evict_r, evict_nxt;
  logic                 res_hit_r, res_hit_nxt;
  logic [FRAME_W-1:0]   res_frame_r, res_frame_nxt;
  logic [FAULT_W-1:0]   faults_r, faults_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic                 out_hit_r;
  logic [FRAME_W-1:0]   out_frame_r;
  logic [FAULT_W-1:0]   out_fault_r;

  logic [31:0]          pid_ext, page_ext;
  logic [IDX_W-1:0]     tag_addr, fill_idx, ring_idx;
  tag_ctl_t             tag_ctl;
  tag_sts_t             tag_sts;
  ring_ctl_t            ring_ctl;
  logic                 in_fire, load_out;

  assign pid_ext  = 32'(in_ch.pid);
  assign page_ext = 32'(in_ch.page);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign load_out = (state_r == S_DONE) && (!out_vld_r || out_ch.ready);
  assign fill_idx = evict_r ? ring_idx : free_idx_r;

  ppft_tag_store #(
    .NUM_FRAMES (NUM_FRAMES),
    .PID_BITS   (PID_BITS),
    .PAGE_BITS  (PAGE_BITS)
  ) u_tag (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (tag_ctl),
    .addr  (tag_addr),
    .pid   (pid_r),
    .page  (page_r),
    .sts   (tag_sts)
  );

  ppft_ring #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ring_ctl),
    .push_idx ((state_r == S_FILL) ? fill_idx : idx_r),
    .head_idx (ring_idx)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    pid_nxt       = pid_r;
    page_nxt      = page_r;
    idx_nxt       = idx_r;
    free_idx_nxt  = free_idx_r;
    free_fnd_nxt  = free_fnd_r;
    evict_nxt     = evict_r;
    res_hit_nxt   = res_hit_r;
    res_frame_nxt = res_frame_r;
    faults_nxt    = faults_r;
    tag_ctl       = '0;
    ring_ctl      = '0;
    tag_addr      = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt       = in_ch.cmd;
          pid_nxt       = pid_ext[PID_BITS-1:0];
          page_nxt      = page_ext[PAGE_BITS-1:0];
          idx_nxt       = '0;
          free_fnd_nxt  = 1'b0;
          res_hit_nxt   = 1'b0;
          res_frame_nxt = '0;
          unique case (in_ch.cmd)
            CMD_ACCESS: begin
              state_nxt = S_RD;
            end
            CMD_RELEASE: begin
              ring_ctl.restart = 1'b1;
              state_nxt        = S_RD;
            end
            CMD_CLEAR: begin
              tag_ctl.clr      = 1'b1;
              ring_ctl.restart = 1'b1;
              faults_nxt       = '0;
              state_nxt        = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_RD: begin
        tag_ctl.rd = 1'b1;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        if (cmd_r == CMD_ACCESS) begin
          ring_ctl.rd = 1'b1;
          if (tag_sts.tag_hit) begin
            res_hit_nxt   = 1'b1;
            res_frame_nxt = FRAME_W'(idx_r);
            state_nxt     = S_DONE;
          end else begin
            if (!tag_sts.used && !free_fnd_r) begin
              free_fnd_nxt = 1'b1;
              free_idx_nxt = idx_r;
            end
            if (idx_r == LAST) begin
              if (faults_r != FAULT_MAX) begin
                faults_nxt = faults_r + 1'b1;
              end
              evict_nxt = !free_fnd_nxt;
              state_nxt = S_FILL;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_RD;
            end
          end
        end else begin
          // release: free owned frames, relink survivors in index order
          if (tag_sts.owner_hit) begin
            tag_ctl.free = 1'b1;
          end else if (tag_sts.used) begin
            ring_ctl.push = 1'b1;
          end
          if (idx_r == LAST) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_FILL: begin
        tag_addr      = fill_idx;
        tag_ctl.wr    = 1'b1;
        ring_ctl.pop  = evict_r;
        ring_ctl.push = 1'b1;
        res_frame_nxt = FRAME_W'(fill_idx);
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (load_out) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      faults_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      faults_r  <= faults_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    pid_r       <= pid_nxt;
    page_r      <= page_nxt;
    idx_r       <= idx_nxt;
    free_idx_r  <= free_idx_nxt;
    free_fnd_r  <= free_fnd_nxt;
    evict_r     <= evict_nxt;
    res_hit_r   <= res_hit_nxt;
    res_frame_r <= res_frame_nxt;
    if (load_out) begin
      out_hit_r   <= res_hit_r;
      out_frame_r <= res_frame_r;
      out_fault_r <= faults_r;
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_vld_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.frame       = out_frame_r;
  assign out_ch.fault_count = out_fault_r;

endmodule
